// File: hdl/qcfr_pkg.sv
// Shared types and constants for the QUIC CRYPTO frame reassembler.
// Used by the core and by its checker; no dependencies.
package qcfr_pkg;

  // Reassembly buffer size and longest message, in bytes.
  localparam int unsigned BUF_SIZE = 2048;
  localparam int unsigned MAX_MSG  = 4096;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REM_W  = 13;
  localparam int unsigned ADDR_W = 11;
  localparam int unsigned STAT_W = 2;

  localparam logic [REM_W-1:0] MAX_REM   = REM_W'(MAX_MSG);
  localparam logic [REM_W:0]   BUF_LIMIT = (REM_W + 1)'(BUF_SIZE);

  // Frame type codes.
  localparam logic [BYTE_W-1:0] FT_PADDING = 8'h00;
  localparam logic [BYTE_W-1:0] FT_PING    = 8'h01;
  localparam logic [BYTE_W-1:0] FT_CRYPTO  = 8'h06;

  // Low six bits of the first varint byte carry value bits.
  localparam logic [5:0] VARINT_MASK = 6'h3F;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_OFFSET,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PARSING,
    ST_CLEAN,
    ST_UNKNOWN,
    ST_MALFORMED
  } status_t;

endpackage

// File: hdl/quic_crypto_frame_reassembler_core.sv
// QUIC decrypted-payload frame walker with CRYPTO reassembly buffer writes.
// Depends on qcfr_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one payload byte per beat, with the
//   count of bytes left in the message including this one (1 or 0 = last).
//   Result channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order. A result carries a buffer write (enable, address, byte)
//   for CRYPTO payload bytes that fit the buffer, the running parse status
//   and a message_end flag on the last byte's result.
// Pipeline and throughput:
//   An accepted input beat passes one input register, then the result
//   register. One beat per cycle sustained while out_stall is low; the per-byte
//   phase update is combinational between those two registers.
// Stalls:
//   The input register holds a beat while the result register is full and
//   stalled; in_stall rises only then. Nothing is dropped or repeated.
// Reset:
//   Synchronous, active low. Parser returns to "expect frame type" and both
//   pipeline registers empty. Parser state also returns to reset values after
//   every last byte, so each message starts clean.
// Varints are tracked as 13 value bits plus a sticky "too big" flag; any
// value past that range can only ever fail the length check or the fit test.
module quic_crypto_frame_reassembler_core
  import qcfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [REM_W-1:0]  in_bytes_remaining,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_write_enable,
  output logic [ADDR_W-1:0] out_write_address,
  output logic [BYTE_W-1:0] out_write_byte,
  output logic [STAT_W-1:0] out_parse_status,
  output logic              out_message_end
);

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [REM_W-1:0]  s1_rem_r;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_we_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [BYTE_W-1:0] out_byte_r;
  status_t           out_status_r;
  logic              out_end_r;

  // Parser state
  phase_t            phase_r, phase_nxt, phase_stp;
  logic [REM_W-1:0]  vacc_r, vacc_nxt;      // varint value bits
  logic              vbig_r, vbig_nxt;      // varint exceeds 13 bits
  logic [2:0]        vleft_r, vleft_nxt;    // varint bytes still to come
  logic [REM_W-1:0]  off_r, off_nxt;        // CRYPTO offset, low bits
  logic              off_big_r, off_big_nxt;
  logic [REM_W-1:0]  pleft_r, pleft_nxt;    // payload bytes left
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;
  logic              copy_r, copy_nxt;
  status_t           stop_r, stop_nxt, stop_stp;

  // Handshake
  logic s1_move;
  logic in_take;

  assign s1_move       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_move;
  assign in_take       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_move);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  // Message bookkeeping
  logic [REM_W-1:0] rem_sat;
  logic [REM_W-1:0] avail;
  logic             last;

  assign rem_sat = (s1_rem_r > MAX_REM) ? MAX_REM : s1_rem_r;
  assign last    = rem_sat <= REM_W'(1);
  assign avail   = (rem_sat == '0) ? '0 : rem_sat - REM_W'(1);

  // Varint byte step
  logic                    vfirst;
  logic [3:0]              vlen;
  logic                    vshort;
  logic [REM_W+BYTE_W-1:0] vshift;
  logic [REM_W-1:0]        vacc_v;
  logic                    vbig_v;
  logic [2:0]              vleft_v;
  logic                    vdone;

  assign vfirst = (vleft_r == '0);
  assign vlen   = 4'd1 << s1_byte_r[7:6];
  assign vshort = vfirst && (rem_sat < {{(REM_W-4){1'b0}}, vlen});
  assign vshift = {vacc_r, s1_byte_r};

  always_comb begin
    if (vfirst) begin
      vacc_v  = {{(REM_W-6){1'b0}}, s1_byte_r[5:0] & VARINT_MASK};
      vbig_v  = 1'b0;
      vleft_v = 3'(vlen - 4'd1);
    end else begin
      vacc_v  = vshift[REM_W-1:0];
      vbig_v  = vbig_r || (|vshift[REM_W+BYTE_W-1:REM_W]);
      vleft_v = vleft_r - 3'd1;
    end
  end

  assign vdone = !vshort && (vleft_v == '0);

  // Length and buffer fit tests
  logic             len_over;
  logic [REM_W:0]   fit_sum;
  logic             fits;
  logic [REM_W-1:0] pleft_dec;

  assign len_over  = vbig_v || (vacc_v > avail);
  assign fit_sum   = {1'b0, off_r} + {1'b0, vacc_v};
  assign fits      = !off_big_r && (fit_sum <= BUF_LIMIT);
  assign pleft_dec = (pleft_r != '0) ? pleft_r - REM_W'(1) : '0;

  // Next state
  always_comb begin
    phase_stp   = phase_r;
    stop_stp    = stop_r;
    vacc_nxt    = vacc_r;
    vbig_nxt    = vbig_r;
    vleft_nxt   = vleft_r;
    off_nxt     = off_r;
    off_big_nxt = off_big_r;
    pleft_nxt   = pleft_r;
    wptr_nxt    = wptr_r;
    copy_nxt    = copy_r;

    case (phase_r)
      PH_TYPE: begin
        if (s1_byte_r == FT_CRYPTO) begin
          phase_stp = PH_OFFSET;
          vleft_nxt = '0;
        end else if (s1_byte_r > FT_PING) begin
          phase_stp = PH_STOPPED;
          stop_stp  = ST_UNKNOWN;
        end
      end
      PH_OFFSET: begin
        if (vshort) begin
          phase_stp = PH_STOPPED;
          stop_stp  = ST_MALFORMED;
        end else begin
          vacc_nxt  = vacc_v;
          vbig_nxt  = vbig_v;
          vleft_nxt = vleft_v;
          if (vdone) begin
            off_nxt     = vacc_v;
            off_big_nxt = vbig_v;
            phase_stp   = PH_LENGTH;
          end
        end
      end
      PH_LENGTH: begin
        if (vshort) begin
          phase_stp = PH_STOPPED;
          stop_stp  = ST_MALFORMED;
        end else begin
          vacc_nxt  = vacc_v;
          vbig_nxt  = vbig_v;
          vleft_nxt = vleft_v;
          if (vdone) begin
            if (len_over) begin
              phase_stp = PH_STOPPED;
              stop_stp  = ST_MALFORMED;
            end else begin
              pleft_nxt = vacc_v;
              copy_nxt  = fits;
              wptr_nxt  = fits ? off_r[ADDR_W-1:0] : '0;
              phase_stp = (vacc_v != '0) ? PH_PAYLOAD : PH_TYPE;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (copy_r) begin
          wptr_nxt = wptr_r + ADDR_W'(1);
        end
        pleft_nxt = pleft_dec;
        if (pleft_dec == '0) begin
          phase_stp = PH_TYPE;
        end
      end
      default: begin
      end
    endcase

    phase_nxt = phase_stp;
    stop_nxt  = stop_stp;
    // Last byte: back to reset values for the next message.
    if (last) begin
      phase_nxt   = PH_TYPE;
      stop_nxt    = ST_PARSING;
      vacc_nxt    = '0;
      vbig_nxt    = 1'b0;
      vleft_nxt   = '0;
      off_nxt     = '0;
      off_big_nxt = 1'b0;
      pleft_nxt   = '0;
      wptr_nxt    = '0;
      copy_nxt    = 1'b0;
    end
  end

  // Result of this byte
  logic              res_we;
  logic [ADDR_W-1:0] res_addr;
  logic [BYTE_W-1:0] res_byte;
  status_t           res_status;

  always_comb begin
    res_we   = (phase_r == PH_PAYLOAD) && copy_r;
    res_addr = res_we ? wptr_r : '0;
    res_byte = res_we ? s1_byte_r : '0;
    if (phase_stp == PH_STOPPED) begin
      res_status = stop_stp;
    end else if (!last) begin
      res_status = ST_PARSING;
    end else if (phase_stp == PH_TYPE) begin
      res_status = ST_CLEAN;
    end else begin
      res_status = ST_MALFORMED;
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_TYPE;
      stop_r      <= ST_PARSING;
      vacc_r      <= '0;
      vbig_r      <= 1'b0;
      vleft_r     <= '0;
      off_r       <= '0;
      off_big_r   <= 1'b0;
      pleft_r     <= '0;
      wptr_r      <= '0;
      copy_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) begin
        phase_r   <= phase_nxt;
        stop_r    <= stop_nxt;
        vacc_r    <= vacc_nxt;
        vbig_r    <= vbig_nxt;
        vleft_r   <= vleft_nxt;
        off_r     <= off_nxt;
        off_big_r <= off_big_nxt;
        pleft_r   <= pleft_nxt;
        wptr_r    <= wptr_nxt;
        copy_r    <= copy_nxt;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_rem_r  <= in_bytes_remaining;
    end
    if (s1_move) begin
      out_we_r     <= res_we;
      out_addr_r   <= res_addr;
      out_byte_r   <= res_byte;
      out_status_r <= res_status;
      out_end_r    <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_addr_r;
  assign out_write_byte    = out_byte_r;
  assign out_parse_status  = out_status_r;
  assign out_message_end   = out_end_r;

endmodule

// File: hdl/qcfr_checker.sv
// Port-level checks for quic_crypto_frame_reassembler_core, bound to it below.
// Depends on qcfr_pkg.
module qcfr_checker
  import qcfr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_data_byte,
  input logic [REM_W-1:0]  in_bytes_remaining,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_write_enable,
  input logic [ADDR_W-1:0] out_write_address,
  input logic [BYTE_W-1:0] out_write_byte,
  input logic [STAT_W-1:0] out_parse_status,
  input logic              out_message_end
);

  logic              out_acc;
  logic              hold_r;      // previous beat stopped mid-message
  logic [STAT_W-1:0] hold_stat_r;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= 1'b0;
      hold_stat_r <= ST_PARSING;
    end else if (out_acc) begin
      hold_r      <= !out_message_end &&
                     (out_parse_status == ST_UNKNOWN || out_parse_status == ST_MALFORMED);
      hold_stat_r <= out_parse_status;
    end
  end

  // A stopped parse keeps its reason until the message ends.
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && hold_r |-> out_parse_status == hold_stat_r)
    else $error("stop reason changed before message end");

  // The last byte always carries a final status.
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_parse_status != ST_PARSING)
    else $error("message end reported while still parsing");

  // Buffer writes only come from a live CRYPTO payload, so never with status ST_UNKNOWN.
  a_write_not_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_parse_status != ST_UNKNOWN)
    else $error("write after unknown frame");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_write_address == '0 && out_write_byte == '0)
    else $error("address or byte nonzero without write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_write_address)
      && $stable(out_write_byte) && $stable(out_parse_status))
    else $error("stalled result beat changed");

endmodule

bind quic_crypto_frame_reassembler_core qcfr_checker u_qcfr_checker (.*);
